@@ rtl/core/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion shorthands, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication check, clocked on clk, off while rst is high
`define CHRG_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("chrg assertion failed");

// Plain invariant, clocked on clk, off while rst is high
`define CHRG_ALWAYS(label, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("chrg invariant failed");

`endif

@@ rtl/core/chrg_pkg.sv @@
// ----------------------------------------------------------------------------
// chrg_pkg
// Shared types and round constants for the counter hash generator.
// ----------------------------------------------------------------------------
package chrg_pkg;

  localparam int unsigned ROUND_COUNT_DEFAULT = 4;
  localparam int unsigned KEY_COUNT           = 4;

  localparam logic [31:0] KEY_IN_TABLE [KEY_COUNT] = '{
    32'hbaa96887, 32'h1e17d32c, 32'h03bcdc3c, 32'h0f33d1b2
  };
  localparam logic [31:0] KEY_OUT_TABLE [KEY_COUNT] = '{
    32'h4b0f3b58, 32'he874f0c3, 32'h6955c5a6, 32'h55a7ca46
  };

  // One request as it travels along the row of round cells
  typedef struct packed {
    logic        valid;
    logic        load;
    logic [63:0] count;
    logic [31:0] left;
    logic [31:0] right;
  } item_t;

endpackage

@@ rtl/core/counter_hash_random_generator.sv @@
// ----------------------------------------------------------------------------
// counter_hash_random_generator
// Counter-mode pseudo-DES hash generator with a 0.32 fraction output.
// ----------------------------------------------------------------------------
// Takes one request per cycle unless stalled, and returns one result per
// request, in order. A draw hashes the current 64-bit counter and then
// increments it; a load sets the counter and returns a zero word with the
// loaded value. Each round is a two-stage cell (products, then mixing), so a
// request passes through both registers of every cell and then the output
// register before its result can be taken. The row of cells stalls as a
// whole only when its last cell holds a result and the output register is
// still waiting to be taken.
`include "assert_macros.svh"

module counter_hash_random_generator #(
  parameter int unsigned ROUND_COUNT = chrg_pkg::ROUND_COUNT_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        func,
  input  logic [63:0] load_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] random_word,
  output logic [63:0] counter_value
);

  logic [63:0]     counter;
  logic            advance;
  logic            accept;
  chrg_pkg::item_t chain [ROUND_COUNT+1];
  chrg_pkg::item_t last;

  assign last     = chain[ROUND_COUNT];
  assign advance  = !last.valid || !out_valid || out_ready;
  assign in_ready = advance;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      counter <= 64'd0;
    end else if (accept) begin
      if (func) begin
        counter <= load_value;
      end else begin
        counter <= counter + 64'd1;
      end
    end
  end

  always_comb begin
    chain[0].valid = accept;
    chain[0].load  = func;
    chain[0].count = func ? load_value : counter;
    chain[0].left  = counter[63:32];
    chain[0].right = counter[31:0];
  end

  for (genvar g = 0; g < ROUND_COUNT; g++) begin : g_round
    localparam logic [1:0] KeySel = 2'(g % chrg_pkg::KEY_COUNT);
    chrg_round_cell #(
      .KEY_IN  (chrg_pkg::KEY_IN_TABLE[KeySel]),
      .KEY_OUT (chrg_pkg::KEY_OUT_TABLE[KeySel])
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .advance  (advance),
      .item_in  (chain[g]),
      .item_out (chain[g+1])
    );
  end

  // Output register: refill whenever empty or being taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      out_valid <= last.valid;
    end
    if (!out_valid || out_ready) begin
      random_word   <= last.load ? 32'd0 : last.right;
      counter_value <= last.count;
    end
  end

  `CHRG_ASSERT(a_load_sets_counter, (accept && func) |=> (counter == $past(load_value)))
  `CHRG_ASSERT(a_draw_steps_counter, (accept && !func) |=> (counter == $past(counter) + 64'd1))
  `CHRG_ASSERT(a_idle_holds_counter, !accept |=> $stable(counter))
  `CHRG_ALWAYS(a_stall_blocks_input, !(last.valid && out_valid && !out_ready && in_ready))

endmodule

@@ rtl/core/chrg_round_cell.sv @@
// ----------------------------------------------------------------------------
// chrg_round_cell
// One Feistel round: products in the first stage, mixing and swap in the second.
// ----------------------------------------------------------------------------
module chrg_round_cell #(
  parameter logic [31:0] KEY_IN  = chrg_pkg::KEY_IN_TABLE[0],
  parameter logic [31:0] KEY_OUT = chrg_pkg::KEY_OUT_TABLE[0]
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            advance,
  input  chrg_pkg::item_t item_in,
  output chrg_pkg::item_t item_out
);

  chrg_pkg::item_t stage;
  logic [31:0]     sq_hi;
  logic [31:0]     sq_lo;
  logic [31:0]     prod;

  logic [31:0] x;
  logic [15:0] hi;
  logic [15:0] lo;
  logic [31:0] sum;
  logic [31:0] mixed;
  logic [31:0] added;

  assign x  = item_in.right ^ KEY_IN;
  assign hi = x[31:16];
  assign lo = x[15:0];

  // Stage one: the three half-word products
  always_ff @(posedge clk) begin
    if (rst) begin
      stage.valid <= 1'b0;
    end else if (advance) begin
      stage.valid <= item_in.valid;
    end
    if (advance) begin
      stage.load  <= item_in.load;
      stage.count <= item_in.count;
      stage.left  <= item_in.left;
      stage.right <= item_in.right;
      sq_hi       <= {16'd0, hi} * {16'd0, hi};
      sq_lo       <= {16'd0, lo} * {16'd0, lo};
      prod        <= {16'd0, hi} * {16'd0, lo};
    end
  end

  assign sum   = ~sq_hi + sq_lo;
  assign mixed = {sum[15:0], sum[31:16]} ^ KEY_OUT;
  assign added = prod + mixed;

  // Stage two: mix into the left half and swap halves
  always_ff @(posedge clk) begin
    if (rst) begin
      item_out.valid <= 1'b0;
    end else if (advance) begin
      item_out.valid <= stage.valid;
    end
    if (advance) begin
      item_out.load  <= stage.load;
      item_out.count <= stage.count;
      item_out.left  <= stage.right;
      item_out.right <= stage.left ^ added;
    end
  end

endmodule
